// File: hdl/free_list_chain_builder_top_macros.svh
// Assertion macros shared by the free-list chain builder.
`ifndef FREE_LIST_CHAIN_BUILDER_TOP_MACROS_SVH
`define FREE_LIST_CHAIN_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FLCB_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);
`define FLCB_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FLCB_ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)
`define FLCB_ASSERT_NEXT(label, clock, reset, ante, cons, msg)
`endif

`endif

// File: hdl/flcb_pkg.sv
`timescale 1ns / 1ps
package flcb_pkg;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_LINK    = 2'd1,
    KIND_COUNT   = 2'd2,
    KIND_SUMMARY = 2'd3
  } word_kind_t;

  typedef enum logic {
    REG_GROUP_SIZE   = 1'b0,
    REG_LOWEST_INDEX = 1'b1
  } reg_index_t;

  localparam logic [7:0]  GROUP_SIZE_RESET   = 8'd254;
  localparam logic [31:0] LOWEST_INDEX_RESET = 32'd1;

  localparam int unsigned HAS_FIRST   = 0;
  localparam int unsigned HAS_COUNT   = 1;
  localparam int unsigned HAS_SUMMARY = 2;

  typedef struct packed {
    logic [2:0]  has;
    word_kind_t  first_kind;
    logic [31:0] first_node;
    logic [7:0]  first_slot;
    logic [31:0] first_value;
    logic [31:0] count_node;
    logic [7:0]  count_value;
    logic [31:0] sum_head;
    logic [31:0] sum_total;
  } rec_t;

endpackage

// File: hdl/flcb_front.sv
`timescale 1ns / 1ps
module flcb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic                wr_index,
  input  logic [31:0]         wr_data,
  input  logic                accept,
  input  logic [31:0]         item_index,
  input  logic                in_use,
  input  logic                scan_end,
  output logic                rec_valid,
  output flcb_pkg::rec_t      rec
);

  logic [7:0]  group_size;
  logic [31:0] lowest_index;
  logic [31:0] open_node;
  logic        node_open;
  logic [7:0]  entry_count;
  logic [31:0] chain_head;
  logic [31:0] free_total;

  logic [31:0] open_node_next;
  logic        node_open_next;
  logic [7:0]  entry_count_next;
  logic [31:0] chain_head_next;
  logic [31:0] free_total_next;

  logic        elig;
  logic [31:0] node1;
  logic        on1;
  logic [7:0]  cnt1;
  logic        close;
  logic [32:0] sum;
  logic [31:0] total1;
  logic [31:0] head1;

  always_comb begin
    elig  = !in_use && (item_index >= lowest_index);
    node1 = open_node;
    on1   = node_open;
    cnt1  = entry_count;
    rec   = '0;
    rec.first_kind = flcb_pkg::KIND_ENTRY;
    if (elig) begin
      rec.has[flcb_pkg::HAS_FIRST] = 1'b1;
      if (!node_open) begin
        rec.first_kind  = flcb_pkg::KIND_LINK;
        rec.first_node  = item_index;
        rec.first_slot  = 8'd0;
        rec.first_value = chain_head;
        node1 = item_index;
        cnt1  = 8'd0;
        on1   = 1'b1;
      end else begin
        rec.first_kind  = flcb_pkg::KIND_ENTRY;
        rec.first_node  = open_node;
        rec.first_slot  = entry_count;
        rec.first_value = item_index;
        cnt1 = entry_count + 8'd1;
      end
    end
    close  = on1 && ((elig && (cnt1 == group_size)) || scan_end);
    sum    = {1'b0, free_total} + {24'd0, {1'b0, cnt1} + 9'd1};
    total1 = close ? (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) : free_total;
    head1  = close ? node1 : chain_head;
    rec.has[flcb_pkg::HAS_COUNT]   = close;
    rec.count_node                 = node1;
    rec.count_value                = cnt1;
    rec.has[flcb_pkg::HAS_SUMMARY] = scan_end;
    rec.sum_head                   = head1;
    rec.sum_total                  = total1;
    rec_valid = accept && (rec.has != 3'd0);
  end

  always_comb begin
    open_node_next   = open_node;
    node_open_next   = node_open;
    entry_count_next = entry_count;
    chain_head_next  = chain_head;
    free_total_next  = free_total;
    if (accept) begin
      if (scan_end) begin
        open_node_next   = '0;
        node_open_next   = 1'b0;
        entry_count_next = '0;
        chain_head_next  = '0;
        free_total_next  = '0;
      end else begin
        open_node_next   = node1;
        node_open_next   = close ? 1'b0 : on1;
        entry_count_next = close ? 8'd0 : cnt1;
        chain_head_next  = head1;
        free_total_next  = total1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size   <= flcb_pkg::GROUP_SIZE_RESET;
      lowest_index <= flcb_pkg::LOWEST_INDEX_RESET;
      open_node    <= '0;
      node_open    <= 1'b0;
      entry_count  <= '0;
      chain_head   <= '0;
      free_total   <= '0;
    end else begin
      if (wr_en) begin
        case (flcb_pkg::reg_index_t'(wr_index))
          flcb_pkg::REG_GROUP_SIZE:   group_size   <= wr_data[7:0];
          flcb_pkg::REG_LOWEST_INDEX: lowest_index <= wr_data;
          default: ;
        endcase
      end
      open_node   <= open_node_next;
      node_open   <= node_open_next;
      entry_count <= entry_count_next;
      chain_head  <= chain_head_next;
      free_total  <= free_total_next;
    end
  end

endmodule

// File: hdl/flcb_queue.sv
`timescale 1ns / 1ps
module flcb_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  flcb_pkg::rec_t wr_rec,
  input  logic           rd,
  output logic           rd_valid,
  output flcb_pkg::rec_t rd_rec,
  output logic           full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  flcb_pkg::rec_t mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign rd_valid = (count != '0);
  assign full     = (count == CW'(DEPTH));
  assign rd_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/flcb_back.sv
`timescale 1ns / 1ps
module flcb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  flcb_pkg::rec_t         q_rec,
  output logic                   q_rd,
  input  logic                   pop,
  output logic                   empty,
  output flcb_pkg::word_kind_t   word_kind,
  output logic [31:0]            node_index,
  output logic [7:0]             slot,
  output logic [31:0]            word_value,
  output logic                   final_res
);

  flcb_pkg::rec_t cur;
  logic [2:0]     left;
  logic           out_valid;

  logic [2:0]           left_next;
  logic [2:0]           sel;
  logic                 out_load;
  logic                 emit;
  flcb_pkg::word_kind_t sel_kind;
  logic [31:0]          sel_node;
  logic [7:0]           sel_slot;
  logic [31:0]          sel_value;

  always_comb begin
    sel = 3'b000;
    if (left[flcb_pkg::HAS_FIRST]) begin
      sel = 3'b001;
    end else if (left[flcb_pkg::HAS_COUNT]) begin
      sel = 3'b010;
    end else if (left[flcb_pkg::HAS_SUMMARY]) begin
      sel = 3'b100;
    end
    case (sel)
      3'b001: begin
        sel_kind  = cur.first_kind;
        sel_node  = cur.first_node;
        sel_slot  = cur.first_slot;
        sel_value = cur.first_value;
      end
      3'b010: begin
        sel_kind  = flcb_pkg::KIND_COUNT;
        sel_node  = cur.count_node;
        sel_slot  = 8'd0;
        sel_value = {24'd0, cur.count_value};
      end
      default: begin
        sel_kind  = flcb_pkg::KIND_SUMMARY;
        sel_node  = cur.sum_head;
        sel_slot  = 8'd0;
        sel_value = cur.sum_total;
      end
    endcase
    out_load  = !out_valid || pop;
    emit      = out_load && (left != 3'd0);
    left_next = emit ? (left & ~sel) : left;
    q_rd      = (left_next == 3'd0) && q_valid;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_rec;
    end
    if (emit) begin
      word_kind  <= sel_kind;
      node_index <= sel_node;
      slot       <= sel_slot;
      word_value <= sel_value;
      final_res  <= ((left & ~sel) == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      left <= q_rd ? q_rec.has : left_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_load) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/free_list_chain_builder_top.sv
`timescale 1ns / 1ps
// Free-list chain builder.
// Allocation-map entries enter on a queue-style port: an entry is taken at a
// clock edge with push high and full low. Free entries at or above the lowest
// index are linked into list nodes, each listing up to group_size entries.
// Result words leave on a second queue-style port: the oldest word is shown
// while empty is low and is taken at an edge with pop high.
// The configuration port writes group_size (index 0) or lowest_index (index 1)
// at any edge with wr_en high; writes are meant for idle periods only.
// A record is queued, loaded into the back stage, then registered as a word.
// The front stage takes one entry per cycle while full is low; the result port
// gives one word per cycle while pop is high, so entries that cause two or
// three words fill the record queue of QUEUE_DEPTH entries, raising full.
// When the receiver holds pop low, the shown word stays put and the queue
// absorbs new entries until it fills. Reset clears the chain state and the
// queue and returns the registers to 254 and 1.
`include "free_list_chain_builder_top_macros.svh"
module free_list_chain_builder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [31:0] wr_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] item_index,
  input  logic        in_use,
  input  logic        scan_end,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  word_kind,
  output logic [31:0] node_index,
  output logic [7:0]  slot,
  output logic [31:0] word_value,
  output logic        final_res
);

  logic                 accept;
  logic                 rec_valid;
  flcb_pkg::rec_t       rec;
  logic                 q_valid;
  flcb_pkg::rec_t       q_rec;
  logic                 q_rd;
  flcb_pkg::word_kind_t kind;

  assign accept    = push && !full;
  assign word_kind = kind;

  flcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .accept     (accept),
    .item_index (item_index),
    .in_use     (in_use),
    .scan_end   (scan_end),
    .rec_valid  (rec_valid),
    .rec        (rec)
  );

  flcb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (rec_valid),
    .wr_rec   (rec),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_rec   (q_rec),
    .full     (full)
  );

  flcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_rec      (q_rec),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .word_kind  (kind),
    .node_index (node_index),
    .slot       (slot),
    .word_value (word_value),
    .final_res  (final_res)
  );

  `FLCB_ASSERT_IMPLIES(a_summary_final, clk, rst, !empty && (kind == flcb_pkg::KIND_SUMMARY), final_res, "summary word without final mark")
  `FLCB_ASSERT_IMPLIES(a_end_makes_record, clk, rst, accept && scan_end, rec_valid, "scan end produced no record")
  `FLCB_ASSERT_IMPLIES(a_no_write_when_full, clk, rst, full, !rec_valid, "record written into a full queue")
  `FLCB_ASSERT_NEXT(a_record_queued, clk, rst, rec_valid, q_valid, "written record missing from the queue")

endmodule
